>>> sv/etpq_pkg.sv
package etpq_pkg;

    // Field widths
    localparam int SEQ_W  = 16;
    localparam int TYPE_W = 4;
    localparam int TIME_W = 32;

    // Default capacity
    localparam int DEPTH_DEF = 16;

    // Events seeded at reset
    localparam logic [TYPE_W-1:0] START_TYPE = TYPE_W'(1);
    localparam logic [TYPE_W-1:0] END_TYPE   = TYPE_W'(8);
    localparam logic [TIME_W-1:0] END_TIME   = TIME_W'(10000);

    // Request kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // One queue entry
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TYPE_W-1:0] etype;
        logic [TIME_W-1:0] ev_time;
    } entry_t;

    // Operation broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } cmd_t;

endpackage

>>> sv/etpq_cell.sv
module etpq_cell
    import etpq_pkg::*;
#(
    parameter logic   RST_VALID = 1'b0,
    parameter entry_t RST_ENTRY = '0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  cmd_t   cmd,
    input  entry_t new_entry,
    input  entry_t left_entry,
    input  logic   left_valid,
    input  logic   left_gt,
    input  entry_t right_entry,
    input  logic   right_valid,
    output entry_t entry,
    output logic   valid,
    output logic   gt
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;

    // Empty cell or later time: new entry belongs at or before this cell
    always_comb
    begin
        gt = !valid_reg || (entry_reg.ev_time > new_entry.ev_time);
    end

    // Pop shifts toward the head; push shifts toward the tail from the insert point
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        priority if (cmd.pop)
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
        else if (cmd.push)
        begin
            valid_next = valid_reg | left_valid;
            priority if (left_gt)
            begin
                entry_next = left_entry;
            end
            else if (gt)
            begin
                entry_next = new_entry;
            end
            else
            begin
                // insert point lies further toward the tail
                entry_next = entry_reg;
            end
        end
        else
        begin
            // no push or pop this cycle
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= RST_VALID;
            entry_reg <= RST_ENTRY;
        end
        else
        begin
            valid_reg <= valid_next;
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

>>> sv/event_time_priority_queue_core.sv
// Bounded event queue kept in ascending order of event time, built as a row of
// DEPTH cells. A request with tuser 0 pushes an event; it goes behind every held
// event of equal or earlier time, or is refused with status full when DEPTH
// events are held. A request with tuser 1 pops the earliest event, or returns
// status empty. Every request yields one result carrying the occupancy after it.
// All cells compare against the incoming time and shift in parallel, so a new
// request is taken every cycle as long as the result register is free or being
// drained. After reset the queue holds a start event (type 1, time 0) and an
// end event (type 8, time 10000).
module event_time_priority_queue_core
    import etpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int IN_DW = ((SEQ_W + TYPE_W + TIME_W + 7) / 8) * 8,
    localparam int OUT_DW = ((SEQ_W + TYPE_W + TIME_W + CW + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_DW-1:0]  s_tdata,  // job_seq, event_type, event_time, zero pad
    input  logic              s_tuser,  // kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_DW-1:0] m_tdata,  // out_seq, out_type, out_time, occupancy, zero pad
    output logic [1:0]        m_tuser   // status
);

    localparam int PAYLOAD_W = SEQ_W + TYPE_W + TIME_W;

    entry_t new_entry;
    cmd_t   cmd;
    logic   in_fire;
    logic   full;
    logic   empty;

    entry_t cell_entry [DEPTH];
    logic   cell_valid [DEPTH];
    logic   cell_gt    [DEPTH];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic          m_valid_reg;
    logic          m_valid_next;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    entry_t        pop_reg;
    entry_t        pop_next;
    logic [CW-1:0] occ_reg;

    // Request decode
    assign new_entry.seq     = s_tdata[SEQ_W-1:0];
    assign new_entry.etype   = s_tdata[SEQ_W+TYPE_W-1:SEQ_W];
    assign new_entry.ev_time = s_tdata[PAYLOAD_W-1:SEQ_W+TYPE_W];

    assign s_tready = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign full     = cell_valid[DEPTH-1];
    assign empty    = !cell_valid[0];
    assign cmd.push = in_fire && (s_tuser == KIND_PUSH) && !full;
    assign cmd.pop  = in_fire && (s_tuser == KIND_POP) && !empty;

    // Row of cells, head at index 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic   RV = (i < 2);
        localparam entry_t RE = (i == 0) ? entry_t'{seq: '0, etype: START_TYPE, ev_time: '0}
                              : (i == 1) ? entry_t'{seq: '0, etype: END_TYPE, ev_time: END_TIME}
                              : entry_t'('0);
        entry_t l_entry;
        logic   l_valid;
        logic   l_gt;
        entry_t r_entry;
        logic   r_valid;

        if (i == 0)
        begin : g_head
            assign l_entry = '0;
            assign l_valid = 1'b1;
            assign l_gt    = 1'b0;
        end
        else
        begin : g_mid_l
            assign l_entry = cell_entry[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_gt    = cell_gt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign r_entry = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_entry = cell_entry[i+1];
            assign r_valid = cell_valid[i+1];
        end

        etpq_cell #(
            .RST_VALID (RV),
            .RST_ENTRY (RE)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .new_entry   (new_entry),
            .left_entry  (l_entry),
            .left_valid  (l_valid),
            .left_gt     (l_gt),
            .right_entry (r_entry),
            .right_valid (r_valid),
            .entry       (cell_entry[i]),
            .valid       (cell_valid[i]),
            .gt          (cell_gt[i])
        );
    end

    // Fill count and result
    always_comb
    begin
        count_next   = count_reg;
        status_next  = status_reg;
        pop_next     = pop_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (in_fire)
        begin
            m_valid_next = 1'b1;
            status_next  = ST_OK;
            pop_next     = '0;
            unique case (s_tuser)
                KIND_PUSH:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                        count_next = count_reg + CW'(1);
                end
                KIND_POP:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        pop_next   = cell_entry[0];
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= CW'(2);
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg <= status_next;
            pop_reg    <= pop_next;
            occ_reg    <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = OUT_DW'({occ_reg, pop_reg.ev_time, pop_reg.etype, pop_reg.seq});

endmodule

>>> test/etpq_checker.sv
`timescale 1ns / 1ps

// Watches both streams, predicts every result and compares in order
module etpq_checker
    import etpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IN_W  = 56,
    parameter int OUT_W = 64,
    parameter int OCC_W = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // job_seq, event_type, event_time, zero pad
    input  logic             s_tuser,   // kind
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,   // out_seq, out_type, out_time, occupancy, zero pad
    input  logic [1:0]       m_tuser,   // status
    output int               errors,
    output int               pending,
    output int               pushes,
    output int               pops,
    output int               full_hits,
    output int               empty_hits,
    output int               results
);

    typedef struct packed {
        logic [1:0]       status;
        entry_t           ev;
        logic [OCC_W-1:0] occ;
    } outcome_t;

    // Shadow copy of the sorted queue
    entry_t     held [DEPTH];
    int         fill;
    outcome_t   expected_q [$];
    int         err_cnt;
    int         push_cnt;
    int         pop_cnt;
    int         full_cnt;
    int         empty_cnt;
    int         result_cnt;

    // Apply one request to the shadow queue and return its result
    function automatic outcome_t apply_request(input logic kind, input entry_t ev);
        outcome_t res;
        int       pos;
        res = '0;
        if (kind == KIND_PUSH) begin
            if (fill >= DEPTH) begin
                res.status = ST_FULL;
            end
            else begin
                // new event goes behind every held event of equal or earlier time
                pos = fill;
                while (pos > 0 && held[pos-1].ev_time > ev.ev_time) begin
                    held[pos] = held[pos-1];
                    pos--;
                end
                held[pos] = ev;
                fill++;
                res.status = ST_OK;
            end
        end
        else begin
            if (fill == 0) begin
                res.status = ST_EMPTY;
            end
            else begin
                res.ev = held[0];
                for (int i = 1; i < fill; i++)
                    held[i-1] = held[i];
                fill--;
                res.status = ST_OK;
            end
        end
        res.occ = OCC_W'(fill);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        outcome_t got;
        entry_t   req;
        if (!rst_n) begin
            // seed start and end events
            for (int i = 0; i < DEPTH; i++)
                held[i] = '0;
            held[0].etype   = START_TYPE;
            held[1].etype   = END_TYPE;
            held[1].ev_time = END_TIME;
            fill       = 2;
            expected_q.delete();
            err_cnt    = 0;
            push_cnt   = 0;
            pop_cnt    = 0;
            full_cnt   = 0;
            empty_cnt  = 0;
            result_cnt = 0;
            errors     <= 0;
            pending    <= 0;
            pushes     <= 0;
            pops       <= 0;
            full_hits  <= 0;
            empty_hits <= 0;
            results    <= 0;
        end
        else begin
            // result side first: a result never belongs to a request taken this edge
            if (m_tvalid && m_tready) begin
                result_cnt++;
                got.status     = m_tuser;
                got.ev.seq     = m_tdata[SEQ_W-1:0];
                got.ev.etype   = m_tdata[SEQ_W +: TYPE_W];
                got.ev.ev_time = m_tdata[SEQ_W+TYPE_W +: TIME_W];
                got.occ        = m_tdata[SEQ_W+TYPE_W+TIME_W +: OCC_W];
                if (expected_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: unexpected result st=%0d seq=%h type=%h time=%h occ=%0d",
                                 $time, got.status, got.ev.seq, got.ev.etype,
                                 got.ev.ev_time, got.occ);
                end
                else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected st=%0d seq=%h type=%h time=%h occ=%0d",
                                     want.status, want.ev.seq, want.ev.etype,
                                     want.ev.ev_time, want.occ);
                            $display("  actual   st=%0d seq=%h type=%h time=%h occ=%0d",
                                     got.status, got.ev.seq, got.ev.etype,
                                     got.ev.ev_time, got.occ);
                        end
                    end
                end
            end

            // request side
            if (s_tvalid && s_tready) begin
                req.seq     = s_tdata[SEQ_W-1:0];
                req.etype   = s_tdata[SEQ_W +: TYPE_W];
                req.ev_time = s_tdata[SEQ_W+TYPE_W +: TIME_W];
                want = apply_request(s_tuser, req);
                if (s_tuser == KIND_PUSH)
                    push_cnt++;
                else
                    pop_cnt++;
                if (want.status == ST_FULL)
                    full_cnt++;
                if (want.status == ST_EMPTY)
                    empty_cnt++;
                expected_q.push_back(want);
            end

            errors     <= err_cnt;
            pending    <= expected_q.size();
            pushes     <= push_cnt;
            pops       <= pop_cnt;
            full_hits  <= full_cnt;
            empty_hits <= empty_cnt;
            results    <= result_cnt;
        end
    end

endmodule

>>> test/tb_event_time_priority_queue_core.sv
`timescale 1ns / 1ps

module tb_event_time_priority_queue_core;
    import etpq_pkg::*;

    localparam int IN_W        = ((SEQ_W + TYPE_W + TIME_W + 7) / 8) * 8;
    localparam int OCC_W       = $clog2(DEPTH_DEF + 1);
    localparam int OUT_W       = ((SEQ_W + TYPE_W + TIME_W + OCC_W + 7) / 8) * 8;
    localparam int RAND_ITEMS  = 1230;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;   // job_seq, event_type, event_time, zero pad
    logic             s_tuser  = KIND_PUSH;   // kind
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;   // out_seq, out_type, out_time, occupancy, zero pad
    logic [1:0]       m_tuser;   // status

    int errors;
    int pending;
    int pushes;
    int pops;
    int full_hits;
    int empty_hits;
    int results;
    int idle_cycles = 0;
    int tie_base    = 0;

    always #5 clk = ~clk;

    event_time_priority_queue_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    etpq_checker #(
        .DEPTH (DEPTH_DEF),
        .IN_W  (IN_W),
        .OUT_W (OUT_W),
        .OCC_W (OCC_W)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .errors     (errors),
        .pending    (pending),
        .pushes     (pushes),
        .pops       (pops),
        .full_hits  (full_hits),
        .empty_hits (empty_hits),
        .results    (results)
    );

    // Offer one request and hold it until taken; valid stays high afterwards
    task automatic offer(input logic kind, input logic [SEQ_W-1:0] seq,
                         input logic [TYPE_W-1:0] et, input logic [TIME_W-1:0] tm);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= IN_W'({tm, et, seq});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Random request; times cluster so that ties and the end event get hit
    task automatic send_random(input int push_pct);
        logic [TIME_W-1:0] tm;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 40)
            tm = TIME_W'(tie_base + $urandom_range(7));
        else if (pick < 55)
            tm = END_TIME - 2 + $urandom_range(4);
        else if (pick < 85)
            tm = $urandom;
        else
        begin
            case ($urandom_range(2))
                0:       tm = '0;
                1:       tm = '1;
                default: tm = END_TIME;
            endcase
        end
        offer(($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP,
              SEQ_W'($urandom), TYPE_W'($urandom), tm);
    endtask

    // Stimulus and verdict
    initial
    begin
        int sent;
        int seg_left;
        int push_pct;
        int burst;
        bit paused;
        sent     = 0;
        seg_left = 0;
        push_pct = 50;
        paused   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: seeded events, extremes, ties, empty queue
        offer(KIND_POP,  16'h0000, 4'h0, 32'h0000_0000);   // start event leaves first
        offer(KIND_PUSH, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);   // all-ones fields
        offer(KIND_PUSH, 16'h0000, 4'h0, 32'h0000_0000);   // all-zero fields
        offer(KIND_PUSH, 16'h1234, 4'h3, END_TIME);        // tie with end event
        offer(KIND_PUSH, 16'h0005, 4'h2, 32'h0000_0000);   // tie at time zero
        offer(KIND_POP,  16'hFFFF, 4'hF, 32'hFFFF_FFFF);
        offer(KIND_POP,  16'h0000, 4'h0, 32'h0000_0000);
        offer(KIND_POP,  16'h0000, 4'h0, 32'h0000_0000);
        offer(KIND_POP,  16'h0000, 4'h0, 32'h0000_0000);
        offer(KIND_POP,  16'h0000, 4'h0, 32'h0000_0000);
        offer(KIND_POP,  16'h0000, 4'h0, 32'h0000_0000);   // pop on empty
        offer(KIND_POP,  16'hFFFF, 4'hF, 32'hFFFF_FFFF);   // empty again
        offer(KIND_PUSH, 16'hAAAA, 4'hA, 32'h0000_0007);
        offer(KIND_PUSH, 16'h5555, 4'h5, 32'h0000_0003);   // goes in front
        offer(KIND_PUSH, 16'h8001, 4'h9, 32'h8000_0000);   // msb of time set
        offer(KIND_POP,  16'h0000, 4'h0, 32'h0000_0000);
        offer(KIND_POP,  16'h0000, 4'h0, 32'h0000_0000);
        offer(KIND_POP,  16'h0000, 4'h0, 32'h0000_0000);

        // random bursts; segments lean toward push or pop to reach full and empty
        while (sent < RAND_ITEMS)
        begin
            if (seg_left <= 0)
            begin
                seg_left = $urandom_range(10, 60);
                case ($urandom_range(2))
                    0:       push_pct = 85;
                    1:       push_pct = 50;
                    default: push_pct = 15;
                endcase
                tie_base = $urandom_range(1000);
            end
            burst = $urandom_range(1, 16);
            while (burst > 0 && sent < RAND_ITEMS)
            begin
                send_random(push_pct);
                sent++;
                seg_left--;
                burst--;
            end
            // let all pending results drain completely once
            if (!paused && sent >= 600)
            begin
                idle_gap(1);
                while (pending != 0)
                    @(posedge clk);
                paused = 1;
            end
            if ($urandom_range(99) >= 30)
                idle_gap($urandom_range(1, 6));
        end

        idle_gap(1);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Run covered %0d requests: %0d pushes, %0d pops, %0d results checked.",
                 pushes + pops, pushes, pops, results);
        $display("Pushes refused as full: %0d, pops on empty: %0d, mismatches: %0d.",
                 full_hits, empty_hits, errors);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result side: varying stall patterns plus one long hold-off
    initial
    begin
        int  mode;
        int  len;
        bit  held_off;
        held_off = 0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held_off && results >= 400)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held_off = 1;
            end
            mode = $urandom_range(3);
            len  = $urandom_range(8, 64);
            for (int k = 0; k < len; k++)
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(99) < 50);
                    2:       m_tready <= ((k % 4) != 3);
                    default: m_tready <= ($urandom_range(99) < 85);
                endcase
                @(posedge clk);
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout after %0d cycles without a transfer", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

>>> sim.f
sv/etpq_pkg.sv
sv/etpq_cell.sv
sv/event_time_priority_queue_core.sv
test/etpq_checker.sv
test/tb_event_time_priority_queue_core.sv
